[rtl/bcsf_pkg.sv]
// Shared types and constants for the binary cave smoothing filter.
// Used by bcsf_lane, bcsf_row and binary_cave_smoothing_filter; no dependencies.
`default_nettype none

package bcsf_pkg;

  localparam int CELLS_W = 64;  // line width on the stream ports
  localparam int WIDTH_W = 7;   // active_width register width
  localparam int INDEX_W = 8;   // configuration register index width

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_ACTIVE_WIDTH = 8'd0;
  localparam logic [INDEX_W-1:0] REG_USE_FAR_RULE = 8'd1;

  localparam logic [WIDTH_W-1:0] ACTIVE_WIDTH_RST = 7'd44;

  // thresholds of the automaton rule
  localparam logic [3:0] NEAR_MIN = 4'd5;
  localparam logic [4:0] FAR_MAX  = 5'd2;

  // lines_seen saturates here: a full five-line window is available
  localparam logic [1:0] SEEN_FULL = 2'd3;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_NONE = 2'd0;

  // control that travels from the sequencer to the lane row
  typedef struct packed {
    logic               smooth;    // apply the rule to interior cells
    logic               use_far;   // far rule enabled
    logic [WIDTH_W-1:0] width;     // effective width, already clamped
  } row_ctrl_t;

endpackage

`default_nettype wire

[rtl/bcsf_lane.sv]
// One lane: wall decision for a single cell from its 5x5 neighbourhood.
// Depends on bcsf_pkg.
`default_nettype none

module bcsf_lane (
  input  wire logic [4:0][4:0] win,      // [row][col], row 2 col 2 is the cell
  input  wire logic            use_far,
  output logic                 wall
);
  import bcsf_pkg::*;

  logic [3:0] near_cnt;
  logic [4:0] far_cnt;

  always_comb begin
    near_cnt = '0;
    far_cnt  = '0;
    for (int r = 1; r <= 3; r++) begin
      for (int c = 1; c <= 3; c++) begin
        near_cnt = near_cnt + 4'(win[r][c]);
      end
    end
    far_cnt = 5'(near_cnt);
    for (int c = 1; c <= 3; c++) begin
      far_cnt = far_cnt + 5'(win[0][c]) + 5'(win[4][c]);
    end
    for (int r = 1; r <= 3; r++) begin
      far_cnt = far_cnt + 5'(win[r][0]) + 5'(win[r][4]);
    end
    wall = (near_cnt >= NEAR_MIN) || (use_far && (far_cnt <= FAR_MAX));
  end

endmodule

`default_nettype wire

[rtl/bcsf_row.sv]
// Row of smoothing lanes plus the merge of lane results with border pass-through
// and width masking. Depends on bcsf_pkg and bcsf_lane.
`default_nettype none

module bcsf_row #(
  parameter int LANES = 64
) (
  input  wire logic [4:0][LANES-1:0] rows,   // row 2 is the line being produced
  input  wire bcsf_pkg::row_ctrl_t   ctrl,
  output logic [LANES-1:0]           cells
);
  import bcsf_pkg::*;

  logic [4:0][LANES+3:0] pad;
  logic [LANES-1:0]      mask;
  logic [LANES-1:0]      interior;
  logic [LANES-1:0]      wall;

  for (genvar i = 0; i < LANES; i++) begin : g_mask
    localparam logic [7:0] POS = 8'(i);
    assign mask[i]     = POS < {1'b0, ctrl.width};
    assign interior[i] = (POS != 8'd0) && ((POS + 8'd2) <= {1'b0, ctrl.width});
  end

  // pad two floor cells on each side; cells beyond the width read as floor
  for (genvar r = 0; r < 5; r++) begin : g_pad
    assign pad[r] = {2'b00, rows[r] & mask, 2'b00};
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [4:0][4:0] win;
    for (genvar r = 0; r < 5; r++) begin : g_win
      assign win[r] = pad[r][i+4:i];
    end
    bcsf_lane u_lane (
      .win     (win),
      .use_far (ctrl.use_far),
      .wall    (wall[i])
    );
  end

  // merge: interior cells take the lane decision, border cells pass through
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      cells[i] = mask[i] & ((ctrl.smooth && interior[i]) ? wall[i] : rows[2][i]);
    end
  end

endmodule

`default_nettype wire

[rtl/binary_cave_smoothing_filter.sv]
// Top level of the binary cave smoothing filter: stream ports, line history,
// result sequencer and output register. Depends on bcsf_pkg and bcsf_row.
//
// Usage:
//   s_axis carries one map line per transaction (tdata = line_cells, tlast =
//   last_line). m_axis returns result lines (tdata = out_cells, tlast =
//   last_of_run, tuser = end_of_frame). The cfg channel writes active_width
//   (index 0) and use_far_rule (index 1); cfg_ready is always high, and
//   writes are expected only while the block is idle.
//   Throughput: one line per cycle while m_axis_tready stays high, except at
//   frame end: a line that causes one result is taken every cycle; the last
//   line of a frame causes up to three results and so occupies the result
//   sequencer, one result at a time. Each result passes through the job
//   register and then the output register before it appears on m_axis.
//   The first two lines of a frame cause no result unless one is the last line.
//   All lanes of the row evaluate one whole line together, combinationally.
//   Reset clears the line history, the line count, the job and the output
//   valid flag, and loads active_width = 44 and use_far_rule = 1.
//   When the receiver stalls, the output register holds its line; the job
//   register holds the pending results, and s_axis_tready drops once the
//   job cannot retire, so no line is lost.
`default_nettype none

module binary_cave_smoothing_filter #(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input line stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [bcsf_pkg::CELLS_W-1:0]   s_axis_tdata,   // [63:0] line_cells
  input  wire logic                           s_axis_tlast,   // last_line
  // result line stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [bcsf_pkg::CELLS_W-1:0]        m_axis_tdata,   // [63:0] out_cells
  output logic                                m_axis_tlast,   // last_of_run
  output logic                                m_axis_tuser,   // [0] end_of_frame
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bcsf_pkg::INDEX_W-1:0]   cfg_index,
  input  wire logic [bcsf_pkg::WIDTH_W-1:0]   cfg_data
);
  import bcsf_pkg::*;

  localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_WIDTH);

  // configuration
  logic [WIDTH_W-1:0] active_width;
  logic               use_far_rule;

  // line history, index 0 is the newest line
  logic [3:0][MAX_WIDTH-1:0] hist;
  logic [1:0]                lines_seen;

  // job register: snapshot of the window taken when a line is accepted
  logic                      job_valid;
  logic [1:0]                job_j;       // current result slot
  logic [1:0]                job_end;     // final result slot
  logic [1:0]                job_k;       // lines_seen at acceptance
  logic                      job_last;
  logic [4:0][MAX_WIDTH-1:0] snap;        // p3, p2, p1, p0, current line

  // output register
  logic                 out_valid;
  logic [CELLS_W-1:0]   out_cells;
  logic                 out_last;
  logic                 out_eof;

  logic                 out_free;
  logic                 emit;
  logic                 job_done;
  logic                 accept;
  logic                 has_result;
  logic [1:0]           j_start;
  logic [1:0]           j_end;

  logic [6:0][MAX_WIDTH-1:0] seq_rows;
  logic [4:0][MAX_WIDTH-1:0] win_rows;
  row_ctrl_t                 ctrl;
  logic [MAX_WIDTH-1:0]      row_cells;
  logic                      res_final;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width <= ACTIVE_WIDTH_RST;
      use_far_rule <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH: active_width <= cfg_data;
        REG_USE_FAR_RULE: use_far_rule <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: the job retires when its final result moves to the output
  assign out_free      = !out_valid || m_axis_tready;
  assign emit          = job_valid && out_free;
  assign job_done      = emit && (job_j == job_end);
  assign s_axis_tready = !job_valid || job_done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // result slots: slot j smooths or passes window rows j..j+4 of
  // {p3, p2, p1, p0, cur, floor, floor}; the line produced is the window centre
  always_comb begin
    has_result = s_axis_tlast || (lines_seen == SEEN_TWO) || (lines_seen == SEEN_FULL);
    j_end      = s_axis_tlast ? 2'd2 : 2'd0;
    j_start    = 2'd0;
    if (s_axis_tlast) begin
      case (lines_seen) inside
        SEEN_FULL, SEEN_TWO: j_start = 2'd0;
        SEEN_ONE:            j_start = 2'd1;
        default:             j_start = 2'd2;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid  <= 1'b0;
      job_j      <= '0;
      job_end    <= '0;
      job_k      <= SEEN_NONE;
      job_last   <= 1'b0;
      lines_seen <= SEEN_NONE;
      hist       <= '0;
    end else begin
      if (accept) begin
        job_valid <= has_result;
        job_j     <= j_start;
        job_end   <= j_end;
        job_k     <= lines_seen;
        job_last  <= s_axis_tlast;
        // clear the history at frame end, else shift the new line in
        if (s_axis_tlast) begin
          hist       <= '0;
          lines_seen <= SEEN_NONE;
        end else begin
          hist <= {hist[2:0], s_axis_tdata[MAX_WIDTH-1:0]};
          if (lines_seen != SEEN_FULL) begin
            lines_seen <= lines_seen + 2'd1;
          end
        end
      end else if (job_done) begin
        job_valid <= 1'b0;
      end else if (emit) begin
        job_j <= job_j + 2'd1;
      end
    end
  end

  // window snapshot: payload only, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      snap <= {hist[3], hist[2], hist[1], hist[0], s_axis_tdata[MAX_WIDTH-1:0]};
    end
  end

  // select the five rows of the current slot
  always_comb begin
    seq_rows = {snap[4], snap[3], snap[2], snap[1], snap[0],
                {MAX_WIDTH{1'b0}}, {MAX_WIDTH{1'b0}}};
    for (int i = 0; i < 5; i++) begin
      win_rows[i] = seq_rows[3'd6 - (3'(job_j) + 3'(i))];
    end
    ctrl.smooth  = ((job_j == 2'd0) && (job_k == SEEN_FULL)) ||
                   ((job_j == 2'd1) && ((job_k == SEEN_TWO) || (job_k == SEEN_FULL)));
    ctrl.use_far = use_far_rule;
    ctrl.width   = (active_width > MAX_W) ? MAX_W : active_width;
    res_final    = (job_j == job_end);
  end

  bcsf_row #(
    .LANES (MAX_WIDTH)
  ) u_row (
    .rows  (win_rows),
    .ctrl  (ctrl),
    .cells (row_cells)
  );

  // output register: advance on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cells <= CELLS_W'(row_cells);
      out_last  <= res_final;
      out_eof   <= res_final && job_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_cells;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_eof;

endmodule

`default_nettype wire

[tb/bcsf_line_checker.sv]
`timescale 1ns / 1ps
// Line checker for the binary cave smoothing filter: watches the cfg, s_axis and m_axis
// channels, predicts every result line and compares it. Depends on bcsf_pkg.
module bcsf_line_checker #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [bcsf_pkg::CELLS_W-1:0]   s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [bcsf_pkg::CELLS_W-1:0]   m_axis_tdata,
  input  logic                           m_axis_tlast,
  input  logic                           m_axis_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bcsf_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [bcsf_pkg::WIDTH_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             lines_due
);
  import bcsf_pkg::*;

  typedef struct packed {
    logic [CELLS_W-1:0] cells;
    logic               run_end;
    logic               frame_end;
  } gen_line_t;

  gen_line_t          due_lines[$];
  logic [CELLS_W-1:0] history[4];   // index 0 holds the newest line
  logic [1:0]         seen;
  logic [WIDTH_W-1:0] width_reg;
  logic               far_on;

  function automatic int eff_width();
    int w;
    w = int'(width_reg);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (w > CELLS_W) w = CELLS_W;
    return w;
  endfunction

  function automatic logic [CELLS_W-1:0] keep_mask(input int w);
    if (w >= CELLS_W) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic int bit_at(input logic [CELLS_W-1:0] v, input int i);
    if (i < 0 || i > CELLS_W - 1) return 0;
    return int'(v[i]);
  endfunction

  // Next generation of line c, with a and e two lines away and b, d adjacent.
  function automatic logic [CELLS_W-1:0] smooth_line(input logic [CELLS_W-1:0] a,
                                                     input logic [CELLS_W-1:0] b,
                                                     input logic [CELLS_W-1:0] c,
                                                     input logic [CELLS_W-1:0] d,
                                                     input logic [CELLS_W-1:0] e);
    int w;
    int near_walls;
    int far_walls;
    logic [CELLS_W-1:0] m;
    logic [CELLS_W-1:0] res;
    w = eff_width();
    m = keep_mask(w);
    a &= m; b &= m; c &= m; d &= m; e &= m;
    res = c;
    for (int x = 1; x + 1 < w; x++) begin
      near_walls = 0;
      for (int k = -1; k <= 1; k++)
        near_walls += bit_at(b, x + k) + bit_at(c, x + k) + bit_at(d, x + k);
      far_walls = near_walls;
      for (int k = -1; k <= 1; k++)
        far_walls += bit_at(a, x + k) + bit_at(e, x + k);
      far_walls += bit_at(b, x - 2) + bit_at(c, x - 2) + bit_at(d, x - 2);
      far_walls += bit_at(b, x + 2) + bit_at(c, x + 2) + bit_at(d, x + 2);
      res[x] = (near_walls >= int'(NEAR_MIN)) || (far_on && far_walls <= int'(FAR_MAX));
    end
    return res & m;
  endfunction

  function automatic void push_line(input logic [CELLS_W-1:0] cells, input logic run_end,
                                    input logic frame_end);
    gen_line_t item;
    item.cells     = cells;
    item.run_end   = run_end;
    item.frame_end = frame_end;
    due_lines.push_back(item);
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < 4; i++) history[i] = '0;
    seen = SEEN_NONE;
  endfunction

  // Work out the result lines caused by one accepted input line.
  function automatic void record_line(input logic [CELLS_W-1:0] cur, input logic last);
    logic [CELLS_W-1:0] m;
    m = keep_mask(eff_width());
    if (last) begin
      case (seen)
        SEEN_NONE: begin
          push_line(cur & m, 1'b1, 1'b1);
        end
        SEEN_ONE: begin
          push_line(history[0] & m, 1'b0, 1'b0);
          push_line(cur & m, 1'b1, 1'b1);
        end
        SEEN_TWO: begin
          push_line(history[1] & m, 1'b0, 1'b0);
          push_line(smooth_line('0, history[1], history[0], cur, '0), 1'b0, 1'b0);
          push_line(cur & m, 1'b1, 1'b1);
        end
        default: begin
          push_line(smooth_line(history[3], history[2], history[1], history[0], cur),
                    1'b0, 1'b0);
          push_line(smooth_line(history[2], history[1], history[0], cur, '0), 1'b0, 1'b0);
          push_line(cur & m, 1'b1, 1'b1);
        end
      endcase
      clear_frame();
    end else begin
      if (seen == SEEN_TWO)
        push_line(history[1] & m, 1'b1, 1'b0);
      else if (seen == SEEN_FULL)
        push_line(smooth_line(history[3], history[2], history[1], history[0], cur),
                  1'b1, 1'b0);
      history[3] = history[2];
      history[2] = history[1];
      history[1] = history[0];
      history[0] = cur;
      if (seen != SEEN_FULL) seen = seen + 2'd1;
    end
  endfunction

  function automatic void count_mismatch();
    mismatches++;
  endfunction

  initial begin
    mismatches = 0;
    lines_due  = 0;
  end

  always @(posedge clk) begin
    gen_line_t want;
    if (rst) begin
      due_lines.delete();
      clear_frame();
      width_reg = ACTIVE_WIDTH_RST;
      far_on    = 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_WIDTH: width_reg = cfg_data;
          REG_USE_FAR_RULE: far_on = cfg_data[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_lines.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result line: cells %h last %b eof %b",
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
          count_mismatch();
        end else begin
          want = due_lines.pop_front();
          if (want.cells !== m_axis_tdata || want.run_end !== m_axis_tlast ||
              want.frame_end !== m_axis_tuser) begin
            if (mismatches < 10)
              $display("line mismatch: expected cells %h last %b eof %b, got cells %h last %b eof %b",
                       want.cells, want.run_end, want.frame_end,
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
            count_mismatch();
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        record_line(s_axis_tdata, s_axis_tlast);
    end
    lines_due <= due_lines.size();
  end

endmodule

[tb/tb_binary_cave_smoothing_filter.sv]
`timescale 1ns / 1ps
// Testbench top for binary_cave_smoothing_filter: drives map frames and register writes,
// idles both stream sides at random and gives the verdict.
// Depends on bcsf_pkg and bcsf_line_checker.
module tb_binary_cave_smoothing_filter;
  import bcsf_pkg::*;

  localparam int MAX_WIDTH       = 64;
  localparam int SETTLE_CYCLES   = 4;     // margin for results still passing the job and output registers
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASES          = 10;
  localparam int LINES_PER_PHASE = 28;

  // wall density of a generated frame
  typedef enum int {
    DENS_SPARSE, DENS_LOW, DENS_HALF, DENS_HIGH, DENS_DENSE, DENS_SOLID
  } density_t;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [CELLS_W-1:0] s_axis_tdata;    // [63:0] line_cells
  logic               s_axis_tlast;    // last_line
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [CELLS_W-1:0] m_axis_tdata;    // [63:0] out_cells
  logic               m_axis_tlast;    // last_of_run
  logic               m_axis_tuser;    // [0] end_of_frame
  logic               cfg_valid;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index;
  logic [WIDTH_W-1:0] cfg_data;

  int   mismatches;
  int   lines_due;
  int   quiet_cycles;
  logic no_idle;       // set for phases that run both sides flat out

  binary_cave_smoothing_filter #(.MAX_WIDTH(MAX_WIDTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bcsf_line_checker #(.MAX_WIDTH(MAX_WIDTH)) u_line_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .lines_due    (lines_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Per-transaction idle count on either side; zero throughout a flat-out phase.
  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [CELLS_W-1:0] cave_line(input density_t dens);
    logic [CELLS_W-1:0] r1;
    logic [CELLS_W-1:0] r2;
    logic [CELLS_W-1:0] r3;
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    r3 = {$urandom, $urandom};
    case (dens)
      DENS_SPARSE: return r1 & r2 & r3;
      DENS_LOW:    return r1 & r2;
      DENS_HALF:   return r1;
      DENS_HIGH:   return r1 | r2;
      DENS_DENSE:  return r1 | r2 | r3;
      default:     return r1[0] ? '1 : '0;
    endcase
  endfunction

  // Receiver: stall a random number of cycles before each result, then hold ready
  // until the transaction goes through.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Watchdog: end the run if no transaction of any kind goes through for too long.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one line after a random gap; keep valid high across back-to-back lines.
  task automatic send_line(input logic [CELLS_W-1:0] cells, input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cells;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted line, then let the pipeline settle, since
  // the opening lines of a frame may still be in flight with nothing expected.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (lines_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers in two transactions, holding valid high between them.
  task automatic write_settings(input logic [WIDTH_W-1:0] width, input logic far_rule);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ACTIVE_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_USE_FAR_RULE;
    cfg_data  <= {{(WIDTH_W-1){1'b0}}, far_rule};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int n_lines);
    density_t dens;
    dens = density_t'($urandom_range(0, 5));
    for (int i = 0; i < n_lines; i++) begin
      // change density now and then so walls and floor both cluster
      if ($urandom_range(0, 7) == 0) dens = density_t'($urandom_range(0, 5));
      send_line(cave_line(dens), i == n_lines - 1);
    end
  endtask

  function automatic int draw_frame_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 1;
    if (r == 1) return 2;
    if (r <= 15) return $urandom_range(3, 8);
    if (r <= 18) return $urandom_range(9, 16);
    return 30;
  endfunction

  initial begin
    int sent;
    int n;
    logic [WIDTH_W-1:0] width;
    logic far_rule;
    logic [WIDTH_W-1:0] phase_widths[PHASES];

    phase_widths = '{7'd5, 7'd64, 7'd127, 7'd0, 7'd1, 7'd2, 7'd3, 7'd65, 7'd44, 7'd20};
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ACTIVE_WIDTH;
    cfg_data      = '0;
    no_idle       = 1'b0;
    rst           = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings first: one-line and two-line frames flush
    // unchanged, a three-line frame smooths its middle line only.
    send_line('1, 1'b1);
    send_line('0, 1'b0);
    send_line('1, 1'b1);
    send_line({$urandom, $urandom}, 1'b0);
    send_line('1, 1'b0);
    send_line('0, 1'b1);
    // longer frame with checkerboards, solid and empty lines
    send_line(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_line(64'h5555_5555_5555_5555, 1'b0);
    send_line('1, 1'b0);
    send_line('0, 1'b0);
    send_line({$urandom, $urandom}, 1'b1);

    // full width, majority rule only
    wait_idle();
    write_settings(7'd64, 1'b0);
    send_line('1, 1'b0);
    send_line({$urandom, $urandom}, 1'b0);
    send_line(64'h8000_0000_0000_0001, 1'b0);
    send_line('1, 1'b1);

    // width change in the middle of a frame: the stored lines are unmasked
    wait_idle();
    write_settings(7'd64, 1'b1);
    send_line({$urandom, $urandom}, 1'b0);
    send_line({$urandom, $urandom}, 1'b0);
    wait_idle();
    write_settings(7'd6, 1'b1);
    send_line('1, 1'b0);
    send_line({$urandom, $urandom}, 1'b1);

    // Random phases: extreme and out-of-range widths, both rule settings.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      width    = (p == PHASES - 1) ? WIDTH_W'($urandom_range(5, 64)) : phase_widths[p];
      far_rule = (p % 3 != 1);
      write_settings(width, far_rule);
      no_idle = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < LINES_PER_PHASE) begin
        n = draw_frame_length();
        send_frame(n);
        sent += n;
      end
      no_idle = 1'b0;
    end

    // Drain: wait for every outstanding line, then wait DRAIN_CYCLES more for strays.
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (lines_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && lines_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
